// ===== rtl/glo_pkg.sv =====
`timescale 1ns / 1ps

package glo_pkg;

	localparam int STAGES = 9;

	localparam int IN_W  = 88;
	localparam int OUT_W = 40;

	localparam int LEN_OK       = 6;
	localparam int ASCII_A      = 65;
	localparam int ASCII_0      = 48;
	localparam int CELLS_FIELD  = 240;
	localparam int CELLS_SQUARE = 24;

	localparam int AXIS_W = 18;
	localparam int MAG_W  = 17;
	localparam int QMOD_W = 8;
	localparam int REM_W  = 14;
	localparam int RED_W  = 13;
	localparam int POS_W  = 13;
	localparam int FLD_W  = 5;
	localparam int DIG_W  = 4;
	localparam int SUB_W  = 5;
	localparam int RST_W  = 8;

	localparam int RECIP_SHIFT = 32;
	localparam int RECIP_W     = 25;

	localparam int FLD_RECIP   = 17477;
	localparam int FLD_RECIP_W = 15;
	localparam int FLD_SHIFT   = 22;
	localparam int SQ_RECIP    = 171;
	localparam int SQ_RECIP_W  = 8;
	localparam int SQ_SHIFT    = 12;

	localparam logic [OUT_W-1:0] BLANK_LOC = {7'd65, 7'd65, 6'd48, 6'd48, 7'd65, 7'd65};

	typedef logic [STAGES-1:0] stage_en_t;

	typedef struct packed {
		logic [6:0] letter;
		logic [5:0] digit;
		logic [6:0] sub;
	} axis_chars_t;

endpackage

// ===== rtl/grid_locator_offset_unit.sv =====
`timescale 1ns / 1ps

// Moves a six-character grid locator by signed column and row offsets given in
// subsquare cells. Each offset is first reduced by a truncating remainder by
// COLUMN_COUNT (the row offset too), the moved row is clamped to
// [0, ROW_COUNT-1] and the column to [0, COLUMN_COUNT-1], and the result is
// re-encoded. A character count other than six returns AA00AA with tuser set.
// The datapath is a nine-stage pipeline; one transfer is taken every cycle
// while the input is not stalled. Back-pressure reaches the input only once
// every stage holds an item; empty stages fill while the output waits. There
// is no start-up sweep after reset.

module grid_locator_offset_unit #(
	parameter int COLUMN_COUNT = 4320,
	parameter int ROW_COUNT    = 4320
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// char_count[3:0], char_0[11:4], char_1[19:12], char_2[27:20], char_3[35:28],
	// char_4[43:36], char_5[51:44], offset_x[67:52], offset_y[83:68], zero[87:84]
	input  logic [glo_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// out_char_0[6:0], out_char_1[13:7], out_char_2[19:14], out_char_3[25:20],
	// out_char_4[32:26], out_char_5[39:33]
	output logic [glo_pkg::OUT_W-1:0] m_tdata,
	// length_error[0]
	output logic                      m_tuser
);

	import glo_pkg::*;

	stage_en_t   en;
	stage_en_t   vld_q;
	stage_en_t   err_q;
	axis_chars_t row_chars, col_chars;

	always_comb begin
		en[STAGES-1] = !vld_q[STAGES-1] || m_tready;
		for (int i = STAGES - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			err_q[0] <= (s_tdata[3:0] != 4'(LEN_OK));
		end
		for (int i = 1; i < STAGES; i++) begin
			if (en[i]) begin
				err_q[i] <= err_q[i-1];
			end
		end
	end

	glo_axis #(
		.COUNT (ROW_COUNT),
		.MOD   (COLUMN_COUNT)
	) u_row (
		.clk       (clk),
		.en        (en),
		.field_ch  (s_tdata[11:4]),
		.square_ch (s_tdata[27:20]),
		.sub_ch    (s_tdata[43:36]),
		.offset    (s_tdata[83:68]),
		.chars     (row_chars)
	);

	glo_axis #(
		.COUNT (COLUMN_COUNT),
		.MOD   (COLUMN_COUNT)
	) u_col (
		.clk       (clk),
		.en        (en),
		.field_ch  (s_tdata[19:12]),
		.square_ch (s_tdata[35:28]),
		.sub_ch    (s_tdata[51:44]),
		.offset    (s_tdata[67:52]),
		.chars     (col_chars)
	);

	assign s_tready = en[0];
	assign m_tvalid = vld_q[STAGES-1];
	assign m_tuser  = err_q[STAGES-1];
	assign m_tdata  = err_q[STAGES-1] ? BLANK_LOC
		: {col_chars.sub, row_chars.sub, col_chars.digit, row_chars.digit,
			col_chars.letter, row_chars.letter};

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&vld_q) && !m_tready)
		else $error("input stalled with a free stage");

	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == BLANK_LOC)
		else $error("length error without AA00AA");

	a_row_letter: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:0] >= 7'd65 && m_tdata[6:0] <= 7'd90)
		else $error("row field letter out of range");

	a_col_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[25:20] >= 6'd48 && m_tdata[25:20] <= 6'd57)
		else $error("column square digit out of range");

	a_row_sub: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[32:26] >= 7'd65 && m_tdata[32:26] <= 7'd88)
		else $error("row subsquare letter out of range");
`endif

endmodule

// ===== rtl/glo_axis.sv =====
`timescale 1ns / 1ps

module glo_axis #(
	parameter int COUNT = 4320,
	parameter int MOD   = 4320
) (
	input  logic               clk,
	input  glo_pkg::stage_en_t en,
	input  logic [7:0]         field_ch,
	input  logic [7:0]         square_ch,
	input  logic [7:0]         sub_ch,
	input  logic [15:0]        offset,
	output glo_pkg::axis_chars_t chars
);

	import glo_pkg::*;

	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / MOD);
	localparam logic [MAG_W-1:0]   MOD_M = MAG_W'(MOD);
	localparam logic [REM_W-1:0]   MOD_R = REM_W'(MOD);
	localparam logic signed [AXIS_W:0] COUNT_S = (AXIS_W + 1)'(COUNT);
	localparam logic [POS_W-1:0]   COUNT_MAX = POS_W'(COUNT - 1);

	logic signed [AXIS_W-1:0] axis_s1, axis_s2, axis_s3, axis_s4;
	logic                     neg_s1, neg_s2, neg_s3;
	logic [MAG_W-1:0]         mag_s1, mag_s2;
	logic [QMOD_W-1:0]        q_s2;
	logic [REM_W-1:0]         pre_s3;
	logic signed [REM_W-1:0]  dlt_s4;
	logic [POS_W-1:0]         pos_s5, pos_s6;
	logic [FLD_W-1:0]         fld_s6, fld_s7, fld_s8;
	logic [RST_W-1:0]         rest_s7, rest_s8;
	logic [DIG_W-1:0]         dig_s8;
	axis_chars_t              chars_s9;

	logic signed [AXIS_W-1:0] f_v, s_v, u_v, axis_v;
	logic [MAG_W-1:0]         ext_v, mag_v;
	logic [MAG_W+RECIP_W-1:0] qprod_v;
	logic [MAG_W-1:0]         pre_v;
	logic [REM_W-1:0]         red_v;
	logic signed [REM_W-1:0]  dlt_v;
	logic signed [AXIS_W:0]   sum_v;
	logic [POS_W-1:0]         pos_v;
	logic [POS_W+FLD_RECIP_W-1:0] fprod_v;
	logic [POS_W-1:0]         rest_v;
	logic [RST_W+SQ_RECIP_W-1:0] dprod_v;
	logic [RST_W-1:0]         sub_v;

	always_comb begin
		f_v    = $signed({{(AXIS_W-8){1'b0}}, field_ch}) - $signed(AXIS_W'(ASCII_A));
		s_v    = $signed({{(AXIS_W-8){1'b0}}, square_ch}) - $signed(AXIS_W'(ASCII_0));
		u_v    = $signed({{(AXIS_W-8){1'b0}}, sub_ch}) - $signed(AXIS_W'(ASCII_A));
		axis_v = f_v * $signed(AXIS_W'(CELLS_FIELD)) + s_v * $signed(AXIS_W'(CELLS_SQUARE)) + u_v;
		ext_v  = {offset[15], offset};
		mag_v  = offset[15] ? (~ext_v + MAG_W'(1)) : ext_v;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			axis_s1 <= axis_v;
			neg_s1  <= offset[15];
			mag_s1  <= mag_v;
		end
	end

	assign qprod_v = {{RECIP_W{1'b0}}, mag_s1} * {{MAG_W{1'b0}}, RECIP};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			axis_s2 <= axis_s1;
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			q_s2    <= qprod_v[RECIP_SHIFT +: QMOD_W];
		end
	end

	assign pre_v = mag_s2 - MAG_W'({{(MAG_W-QMOD_W){1'b0}}, q_s2} * MOD_M);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			axis_s3 <= axis_s2;
			neg_s3  <= neg_s2;
			pre_s3  <= pre_v[REM_W-1:0];
		end
	end

	always_comb begin
		red_v = (pre_s3 >= MOD_R) ? (pre_s3 - MOD_R) : pre_s3;
		dlt_v = neg_s3 ? -$signed(red_v) : $signed(red_v);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			axis_s4 <= axis_s3;
			dlt_s4  <= dlt_v;
		end
	end

	always_comb begin
		sum_v = $signed({axis_s4[AXIS_W-1], axis_s4})
			+ $signed({{(AXIS_W+1-REM_W){dlt_s4[REM_W-1]}}, dlt_s4});
		priority if (sum_v >= COUNT_S) begin
			pos_v = COUNT_MAX;
		end else if (sum_v[AXIS_W]) begin
			pos_v = '0;
		end else begin
			pos_v = sum_v[POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			pos_s5 <= pos_v;
		end
	end

	assign fprod_v = {{FLD_RECIP_W{1'b0}}, pos_s5} * (POS_W + FLD_RECIP_W)'(FLD_RECIP);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			pos_s6 <= pos_s5;
			fld_s6 <= fprod_v[FLD_SHIFT +: FLD_W];
		end
	end

	assign rest_v = pos_s6 - POS_W'({{(POS_W-FLD_W){1'b0}}, fld_s6} * POS_W'(CELLS_FIELD));

	always_ff @(posedge clk) begin
		if (en[6]) begin
			fld_s7  <= fld_s6;
			rest_s7 <= rest_v[RST_W-1:0];
		end
	end

	assign dprod_v = {{SQ_RECIP_W{1'b0}}, rest_s7} * (RST_W + SQ_RECIP_W)'(SQ_RECIP);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			fld_s8  <= fld_s7;
			rest_s8 <= rest_s7;
			dig_s8  <= dprod_v[SQ_SHIFT +: DIG_W];
		end
	end

	assign sub_v = rest_s8 - RST_W'({{(RST_W-DIG_W){1'b0}}, dig_s8} * RST_W'(CELLS_SQUARE));

	always_ff @(posedge clk) begin
		if (en[8]) begin
			chars_s9.letter <= 7'(ASCII_A) + {{(7-FLD_W){1'b0}}, fld_s8};
			chars_s9.digit  <= 6'(ASCII_0) + {{(6-DIG_W){1'b0}}, dig_s8};
			chars_s9.sub    <= 7'(ASCII_A) + {{(7-SUB_W){1'b0}}, sub_v[SUB_W-1:0]};
		end
	end

	assign chars = chars_s9;

endmodule
